// ----- rtl/crb_pkg.sv -----
// shared constants, types and helpers of the comb resonator bank
package crb_pkg;

    // field and register widths
    localparam int SAMPLE_W      = 16;
    localparam int WORD_W        = 24;
    localparam int IN_GAIN_W     = 13;
    localparam int FB_GAIN_W     = 15;
    localparam int NOTE_W        = 12;
    localparam int NUM_NOTE_REGS = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 15;

    // bank geometry
    localparam int NOTES     = 6;
    localparam int OCTAVES   = 2;
    localparam int MAX_DELAY = 2048;
    localparam int COMBS     = NOTES * OCTAVES;

    localparam int LINE_AW = $clog2(MAX_DELAY);
    localparam int LEN_W   = $clog2(MAX_DELAY + 1);

    // fixed point
    localparam int IN_FRAC  = 16;
    localparam int FB_FRAC  = 14;
    localparam int XPROD_W  = SAMPLE_W + IN_GAIN_W + 1;
    localparam int SCALED_W = XPROD_W - IN_FRAC - 1;
    localparam int PROD_W   = WORD_W + FB_GAIN_W + 1;
    localparam int NW_W     = PROD_W - FB_FRAC + 1;
    localparam int SUM_W    = WORD_W + $clog2(COMBS);

    localparam longint WORD_MAX = (64'sd1 <<< (WORD_W - 1)) - 1;
    localparam longint WORD_MIN = -(64'sd1 <<< (WORD_W - 1));

    // reciprocal for the division by the octave count
    localparam int     MAG_W      = SUM_W;
    localparam int     DIV_SHIFT  = MAG_W + 2;
    localparam int     DIV_MULT_W = DIV_SHIFT + 1;
    localparam longint DIV_MULT   = ((64'sd1 <<< DIV_SHIFT) + OCTAVES - 1) / OCTAVES;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_GAIN    = 3'd0,
        REG_FEEDBACK_GAIN = 3'd1,
        REG_NOTE_A        = 3'd2,
        REG_NOTE_B        = 3'd3,
        REG_NOTE_C        = 3'd4,
        REG_NOTE_D        = 3'd5,
        REG_NOTE_E        = 3'd6,
        REG_NOTE_F        = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } t_state;

    // word handed from one cell to the next
    typedef struct packed {
        logic                       valid;
        logic signed [SCALED_W-1:0] scaled;
        logic signed [SUM_W-1:0]    sum;
    } t_link;

    // clearing sweep broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [LINE_AW-1:0] addr;
    } t_clear;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
        logic signed [WORD_W-1:0] res;
        if (v > WORD_MAX) begin
            res = WORD_W'(WORD_MAX);
        end else if (v < WORD_MIN) begin
            res = WORD_W'(WORD_MIN);
        end else begin
            res = WORD_W'(v);
        end
        return res;
    endfunction

endpackage

// ----- rtl/crb_cell.sv -----
// one comb of the bank: delay line, pointer and feedback multiply
module crb_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  crb_pkg::t_link              i_link,
    input  crb_pkg::t_clear             i_clear,
    input  logic [crb_pkg::LEN_W-1:0]   i_len,
    input  logic [crb_pkg::FB_GAIN_W-1:0] i_fb,
    output crb_pkg::t_link              o_link
);
    import crb_pkg::*;

    logic signed [WORD_W-1:0] r_mem [MAX_DELAY];
    logic signed [WORD_W-1:0] r_rdata;
    logic [LINE_AW-1:0]       r_ptr;
    logic [LINE_AW-1:0]       n_ptr;

    logic                       r_a_v;
    logic signed [SCALED_W-1:0] r_a_scaled;
    logic signed [SUM_W-1:0]    r_a_sum;

    logic                       r_b_v;
    logic signed [SCALED_W-1:0] r_b_scaled;
    logic signed [SUM_W-1:0]    r_b_sum;
    logic signed [WORD_W-1:0]   r_old;
    logic signed [PROD_W-1:0]   r_prod;

    logic                       r_out_v;
    logic signed [SCALED_W-1:0] r_out_scaled;
    logic signed [SUM_W-1:0]    r_out_sum;

    logic signed [NW_W-1:0]   fb_term;
    logic signed [NW_W-1:0]   nw_sum;
    logic signed [WORD_W-1:0] new_word;
    logic [LEN_W-1:0]         p_inc;
    logic                     wr_en;
    logic [LINE_AW-1:0]       wr_addr;
    logic signed [WORD_W-1:0] wr_data;

    // floor of the feedback product plus the scaled input
    always_comb begin
        fb_term  = NW_W'(r_prod >>> FB_FRAC);
        nw_sum   = fb_term + NW_W'(r_b_scaled);
        new_word = sat_word(64'(nw_sum));
    end

    // pointer wraps once it reaches the comb length
    always_comb begin
        p_inc = {1'b0, r_ptr} + LEN_W'(1);
        if (p_inc >= i_len) begin
            n_ptr = '0;
        end else begin
            n_ptr = p_inc[LINE_AW-1:0];
        end
    end

    always_comb begin
        wr_en   = i_clear.en | r_b_v;
        wr_addr = i_clear.en ? i_clear.addr : r_ptr;
        wr_data = i_clear.en ? '0 : new_word;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
            r_ptr   <= '0;
        end else begin
            r_a_v   <= i_link.valid;
            r_b_v   <= r_a_v;
            r_out_v <= r_b_v;
            if (r_b_v) begin
                r_ptr <= n_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_scaled   <= i_link.scaled;
        r_a_sum      <= i_link.sum;
        r_b_scaled   <= r_a_scaled;
        r_b_sum      <= r_a_sum;
        r_old        <= r_rdata;
        r_prod       <= r_rdata * $signed({1'b0, i_fb});
        r_out_scaled <= r_b_scaled;
        r_out_sum    <= r_b_sum + SUM_W'(r_old);
    end

    assign o_link = '{valid: r_out_v, scaled: r_out_scaled, sum: r_out_sum};

endmodule

// ----- rtl/comb_resonator_bank_top.sv -----
// top level of the comb resonator bank: config, input scaling, cell chain, output division
// one sample at a time: a new sample is taken only once the previous result has moved
//   from the chain of comb cells into the output register; a stalled output holds
//   that register full and so holds back the next sample as well
// reset: synchronous, active low; configuration returns to its defaults and a clearing
//   sweep zeroes every delay line while o_in_stall is high
module comb_resonator_bank_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [crb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [crb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [crb_pkg::SAMPLE_W-1:0] i_in_sample,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [crb_pkg::WORD_W-1:0]   o_out_sample
);
    import crb_pkg::*;

    localparam logic [DIV_MULT_W-1:0] DivMultV = DIV_MULT_W'(DIV_MULT);

    // configuration registers
    logic [IN_GAIN_W-1:0] r_in_gain;
    logic [FB_GAIN_W-1:0] r_fb_gain;
    logic [NOTE_W-1:0]    r_note [NUM_NOTE_REGS];
    logic [2:0]           note_sel;

    // control
    t_state             r_state;
    t_state             n_state;
    logic [LINE_AW-1:0] r_clr_addr;
    logic [LINE_AW-1:0] n_clr_addr;
    logic               in_accept;
    logic               out_load;
    t_clear             clear;

    // input scaling stages
    logic                       r_x_v;
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_xp_v;
    logic signed [XPROD_W-1:0]  r_xprod;

    // per-comb lengths and the chain
    logic [LEN_W-1:0] r_len [COMBS];
    t_link            links [COMBS+1];

    // division by the octave count and the output register
    logic                             r_d1_v;
    logic                             r_d1_neg;
    logic [MAG_W-1:0]                 r_mag;
    logic                             r_d2_v;
    logic                             r_d2_neg;
    logic [MAG_W+DIV_MULT_W-1:0]      r_qprod;
    logic [MAG_W-1:0]                 quot;
    logic signed [SUM_W:0]            quot_s;
    logic                             r_res_v;
    logic signed [WORD_W-1:0]         r_res;
    logic                             r_out_valid;
    logic signed [WORD_W-1:0]         r_out_sample;

    // configuration port never pushes back
    assign o_cfg_ready = 1'b1;
    assign note_sel    = 3'(i_cfg_index - REG_NOTE_A);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_gain <= '0;
            r_fb_gain <= '0;
            for (int i = 0; i < NUM_NOTE_REGS; i++) begin
                r_note[i] <= NOTE_W'(100);
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INPUT_GAIN:    r_in_gain <= i_cfg_data[IN_GAIN_W-1:0];
                REG_FEEDBACK_GAIN: r_fb_gain <= i_cfg_data[FB_GAIN_W-1:0];
                default: begin
                    if (i_cfg_index inside {[REG_NOTE_A:REG_NOTE_F]}) begin
                        r_note[note_sel] <= i_cfg_data[NOTE_W-1:0];
                    end
                end
            endcase
        end
    end

    // handshakes: one sample in flight; a finished result may wait in the output register
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_load  = r_res_v && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        clear.en   = 1'b0;
        clear.addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                // zero one word of every line per cycle
                clear.en   = 1'b1;
                n_clr_addr = r_clr_addr + LINE_AW'(1);
                if (r_clr_addr == LINE_AW'(MAX_DELAY - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // input scaling: floor(sample * gain / 2^16)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v  <= 1'b0;
            r_xp_v <= 1'b0;
        end else begin
            r_x_v  <= in_accept;
            r_xp_v <= r_x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x <= i_in_sample;
        end
        r_xprod <= r_x * $signed({1'b0, r_in_gain});
    end

    assign links[0] = '{valid: r_xp_v,
                        scaled: SCALED_W'(r_xprod >>> IN_FRAC),
                        sum: '0};

    // comb lengths: clamped base delay over octave number plus one, at least one;
    // the constant division is a reciprocal multiply
    for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
        for (genvar n = 0; n < NOTES; n++) begin : g_note
            localparam int Div      = k + 1;
            localparam int LenShift = LEN_W + 2;
            localparam int LenMult  = ((1 << LenShift) + Div - 1) / Div;

            logic [LEN_W-1:0]     clamped;
            logic [2*LEN_W+2:0]   len_prod;
            logic [LEN_W-1:0]     len_q;

            assign clamped  = (int'(r_note[n]) > MAX_DELAY) ? LEN_W'(MAX_DELAY)
                                                             : LEN_W'(r_note[n]);
            assign len_prod = clamped * (LEN_W + 3)'(LenMult);
            assign len_q    = len_prod[LenShift +: LEN_W];

            always_ff @(posedge i_clk) begin
                r_len[k*NOTES+n] <= (len_q == '0) ? LEN_W'(1) : len_q;
            end
        end
    end

    // chain of comb cells, each adds its oldest word to the running sum
    for (genvar c = 0; c < COMBS; c++) begin : g_cell
        crb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (links[c]),
            .i_clear (clear),
            .i_len   (r_len[c]),
            .i_fb    (r_fb_gain),
            .o_link  (links[c+1])
        );
    end

    // sum over octave count, truncated toward zero: magnitude, reciprocal multiply, sign
    assign quot   = r_qprod[DIV_SHIFT +: MAG_W];
    assign quot_s = r_d2_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v      <= 1'b0;
            r_d2_v      <= 1'b0;
            r_res_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_d1_v <= links[COMBS].valid;
            r_d2_v <= r_d1_v;
            if (r_d2_v) begin
                r_res_v <= 1'b1;
            end else if (out_load) begin
                r_res_v <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_neg <= links[COMBS].sum[SUM_W-1];
        r_mag    <= links[COMBS].sum[SUM_W-1] ? MAG_W'(-links[COMBS].sum)
                                              : MAG_W'(links[COMBS].sum);
        r_d2_neg <= r_d1_neg;
        r_qprod  <= r_mag * DivMultV;
        if (r_d2_v) begin
            r_res <= sat_word(64'(quot_s));
        end
        if (out_load) begin
            r_out_sample <= r_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

endmodule

// ----- dv/comb_resonator_bank_top_test.sv -----
// self-checking testbench of the comb resonator bank: predictor, sample driver, result monitor
`timescale 1ns / 100ps

module comb_resonator_bank_top_test;
    import crb_pkg::*;

    // register count: two gains and one base delay per note register
    localparam int NUM_REGS        = 2 + NUM_NOTE_REGS;
    // settle time long enough to cover a full drain of the chain
    localparam int SETTLE_CYCLES   = 60;
    // long receiver hold-off, well beyond what the chain can absorb
    localparam int HOLD_OFF_CYCLES = 1500;
    // quiet cycles before the run is declared hung; the clearing sweep after
    // reset and the hold-off above are the longest legal silences
    localparam int HANG_LIMIT      = 12000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_SAMPLES   = 185;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // block ports, every input at a known value from time zero
    logic                        i_cfg_valid  = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data   = '0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_in_sample  = '0;
    logic                        o_out_valid;
    logic                        i_out_stall  = 1'b0;
    logic signed [WORD_W-1:0]    o_out_sample;

    // predictor state: configuration copy, every comb line and its pointer
    logic [IN_GAIN_W-1:0]        gain_in;
    logic [FB_GAIN_W-1:0]        gain_fb;
    logic [NOTE_W-1:0]           note_len [NUM_NOTE_REGS];
    logic signed [WORD_W-1:0]    line_words [COMBS*MAX_DELAY];
    int unsigned                 line_ptr [COMBS];

    // register values of the next setting, index order
    logic [CFG_DATA_W-1:0]       setting [NUM_REGS];

    // samples waiting for the driver, and results waiting for the monitor
    logic signed [SAMPLE_W-1:0]  pending_samples [$];
    logic signed [WORD_W-1:0]    expected_out [$];
    logic signed [WORD_W-1:0]    want_sample;

    int unsigned issued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned result_cnt   = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned settings_cnt = 0;
    int unsigned in_gap       = 0;
    int unsigned out_gap      = 0;
    int unsigned hold_left    = 0;
    int unsigned hold_req     = 0;
    int unsigned hold_seen    = 0;
    int unsigned quiet_cnt    = 0;
    logic        quiet        = 1'b0;

    comb_resonator_bank_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_sample  (i_in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_sample (o_out_sample)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // clip to the 24-bit word range
    function automatic logic signed [WORD_W-1:0] clip_word(input longint v);
        longint lim_hi;
        longint lim_lo;
        lim_hi = (longint'(1) <<< (WORD_W - 1)) - 1;
        lim_lo = -(longint'(1) <<< (WORD_W - 1));
        if (v > lim_hi) begin
            v = lim_hi;
        end else if (v < lim_lo) begin
            v = lim_lo;
        end
        return WORD_W'(v);
    endfunction

    // one sample through every comb: read oldest word, write feedback plus
    // scaled input, step the pointer; result is the read sum over the octaves
    function automatic logic signed [WORD_W-1:0] resonate(input logic signed [SAMPLE_W-1:0] x);
        longint      scaled;
        longint      old;
        longint      total;
        int unsigned base;
        int unsigned span;
        int unsigned p;
        int unsigned c;
        total  = 0;
        // arithmetic shift of a signed product floors, as the block does
        scaled = (longint'(x) * longint'(gain_in)) >>> IN_FRAC;
        for (int k = 0; k < OCTAVES; k++) begin
            for (int n = 0; n < NOTES; n++) begin
                c    = k * NOTES + n;
                base = note_len[n];
                // base delay clamped to the line size, length never below one
                if (base > MAX_DELAY) begin
                    base = MAX_DELAY;
                end
                span = base / (k + 1);
                if (span < 1) begin
                    span = 1;
                end
                // a pointer beyond a shortened length is still used once
                p    = line_ptr[c] % MAX_DELAY;
                old  = line_words[c*MAX_DELAY + p];
                line_words[c*MAX_DELAY + p] =
                    clip_word(((old * longint'(gain_fb)) >>> FB_FRAC) + scaled);
                p++;
                if (p >= span) begin
                    p = 0;
                end
                line_ptr[c] = p;
                total += old;
            end
        end
        // signed division truncates toward zero
        return clip_word(total / OCTAVES);
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet) begin
            return 0;
        end else if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 120);
    endfunction

    // sample mix: full range, extremes and values near zero
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 16'sh7FFF;
        end else if (r < 20) begin
            return 16'sh8000;
        end else if (r < 35) begin
            return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
        end
        return SAMPLE_W'($urandom);
    endfunction

    // register value mixes, extremes and out-of-range values among them
    function automatic logic [CFG_DATA_W-1:0] pick_in_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 15'd6554;
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 6554));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_fb_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 15'd19825;
            2:       return 15'd16384;
            3:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 19825));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_delay();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 15'd2048;
            2:       return CFG_DATA_W'($urandom_range(2049, 4095));
            3:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(1, 40));
        endcase
    endfunction

    // sample driver: holds a stalled word, otherwise idles for the chosen gap
    // and then takes the next pending sample
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_out.push_back(resonate(i_in_sample));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (i_in_valid && o_in_stall) begin
                // word stays on the bus unchanged
            end else if (in_gap != 0) begin
                i_in_valid <= 1'b0;
                in_gap     <= in_gap - 1;
            end else if (pending_samples.size() != 0) begin
                i_in_valid  <= 1'b1;
                i_in_sample <= pending_samples.pop_front();
                in_gap      <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor: compares each accepted word with the oldest prediction
    // and drives the stall, including the long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap     <= 0;
            hold_left   <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                result_cnt = result_cnt + 1;
                if (expected_out.size() == 0) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10) begin
                        $display("result %0d: none expected, got %0d", result_cnt,
                                 o_out_sample);
                    end
                end else begin
                    want_sample = expected_out.pop_front();
                    if (o_out_sample !== want_sample) begin
                        mismatch_cnt = mismatch_cnt + 1;
                        if (mismatch_cnt <= 10) begin
                            $display("result %0d: out_sample expected %0d, got %0d",
                                     result_cnt, want_sample, o_out_sample);
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left   <= hold_left - 1;
            end else if (hold_seen != hold_req) begin
                hold_seen   <= hold_req;
                hold_left   <= HOLD_OFF_CYCLES;
                i_out_stall <= 1'b1;
            end else if (out_gap != 0) begin
                i_out_stall <= 1'b1;
                out_gap     <= out_gap - 1;
            end else begin
                i_out_stall <= 1'b0;
                out_gap     <= pick_gap();
            end
        end
    end

    // hang detection: cycles in a row with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cnt <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= HANG_LIMIT) begin
            $display("no progress for %0d cycles, %0d results still due", quiet_cnt,
                     expected_out.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    // writes the whole register set and mirrors it in the predictor;
    // valid stays high from one register to the next
    task automatic apply_setting();
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_reg'(i);
            i_cfg_data  <= setting[i];
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
            case (t_cfg_reg'(i))
                REG_INPUT_GAIN:    gain_in = setting[i][IN_GAIN_W-1:0];
                REG_FEEDBACK_GAIN: gain_fb = setting[i][FB_GAIN_W-1:0];
                default:           note_len[i - int'(REG_NOTE_A)] = setting[i][NOTE_W-1:0];
            endcase
        end
        i_cfg_valid  <= 1'b0;
        settings_cnt = settings_cnt + 1;
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
        pending_samples.push_back(s);
        issued_cnt = issued_cnt + 1;
    endtask

    // block is idle once every issued sample is in and every result is out
    task automatic wait_idle();
        while (accepted_cnt != issued_cnt || expected_out.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        // predictor at its reset state
        gain_in = '0;
        gain_fb = '0;
        for (int i = 0; i < NUM_NOTE_REGS; i++) begin
            note_len[i] = NOTE_W'(100);
        end
        for (int i = 0; i < COMBS*MAX_DELAY; i++) begin
            line_words[i] = '0;
        end
        for (int i = 0; i < COMBS; i++) begin
            line_ptr[i] = 0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: top gains, shortest lines, zero delay and a delay above the line size
        setting[REG_INPUT_GAIN]    = 15'd6554;
        setting[REG_FEEDBACK_GAIN] = 15'd19825;
        setting[REG_NOTE_A]        = 15'd1;
        setting[REG_NOTE_B]        = 15'd2;
        setting[REG_NOTE_C]        = 15'd3;
        setting[REG_NOTE_D]        = 15'd0;
        setting[REG_NOTE_E]        = 15'd4095;
        setting[REG_NOTE_F]        = 15'd2048;
        apply_setting();
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sh0000);
        push_sample(-16'sd1);
        push_sample(16'sd1);
        push_sample(16'sh7FFF);
        push_sample(16'sh7FFF);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sh5555);
        push_sample(16'shAAAA);
        wait_idle();

        // directed: every data bit set so the gains exceed their range and the lines
        // saturate; the long line of note e shrinks below its pointer
        setting[REG_INPUT_GAIN]    = 15'h7FFF;
        setting[REG_FEEDBACK_GAIN] = 15'h7FFF;
        setting[REG_NOTE_A]        = 15'd2049;
        setting[REG_NOTE_B]        = 15'd5;
        setting[REG_NOTE_C]        = 15'd3;
        setting[REG_NOTE_D]        = 15'h7000;
        setting[REG_NOTE_E]        = 15'd7;
        setting[REG_NOTE_F]        = 15'd1;
        apply_setting();
        for (int i = 0; i < 6; i++) begin
            push_sample(16'sh7FFF);
        end
        for (int i = 0; i < 6; i++) begin
            push_sample(16'sh8000);
        end
        wait_idle();

        // random settings, one phase each; one phase runs without idling and
        // another holds the output back long enough for the input to stall
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            setting[REG_INPUT_GAIN]    = pick_in_gain();
            setting[REG_FEEDBACK_GAIN] = pick_fb_gain();
            for (int i = 0; i < NUM_NOTE_REGS; i++) begin
                setting[int'(REG_NOTE_A) + i] = pick_delay();
            end
            apply_setting();
            quiet <= (ph == 2);
            for (int i = 0; i < PHASE_SAMPLES; i++) begin
                push_sample(pick_sample());
            end
            if (ph == 5) begin
                hold_req <= hold_req + 1;
            end
            wait_idle();
        end

        $display("covered %0d samples under %0d register settings, %0d results compared",
                 accepted_cnt, settings_cnt, result_cnt);
        $display("also saturation, clamping, shrunk lines, no idling and a %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (mismatch_cnt == 0 && expected_out.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatch_cnt,
                     expected_out.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
